// ===== src/kmpp_pkg.sv =====
// Shared types, codes and helper functions for the keyboard/mouse packet parser.
// No dependencies; every other file of the block imports this package.
package kmpp_pkg;

    // Width of the pending motion accumulators (9 to 32).
    localparam int MOTION_WIDTH = 16;
    // Width of the motion fields on the result stream.
    localparam int MOTION_OUT_W = 16;

    // Command queue between the parsing front and the event back end.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    localparam logic [7:0] KEY_OFFSET_RESET = 8'd8;

    // Stream byte codes.
    localparam logic [7:0] FIRST_HEADER  = 8'hF6;
    localparam logic [7:0] MOUSE_HDR_LO  = 8'hF8;
    localparam logic [7:0] MOUSE_HDR_HI  = 8'hFB;
    localparam logic [7:0] HDR_STATUS    = 8'hF7;
    localparam logic [7:0] HDR_ABS_POS   = 8'hFC;
    localparam logic [7:0] HDR_TIME      = 8'hFD;
    localparam logic [7:0] HDR_JOY0      = 8'hFE;
    localparam logic [7:0] HDR_JOY1      = 8'hFF;

    // Bytes still expected after the header byte.
    localparam logic [2:0] REST_NONE   = 3'd0;
    localparam logic [2:0] REST_MOUSE  = 3'd2;
    localparam logic [2:0] REST_STATUS = 3'd5;
    localparam logic [2:0] REST_ABS    = 3'd6;
    localparam logic [2:0] REST_TIME   = 3'd2;
    localparam logic [2:0] REST_JOY    = 3'd1;

    localparam logic [2:0] REST_DX = 3'd2;
    localparam logic [2:0] REST_DY = 3'd1;

    localparam logic [7:0] BTN_LEFT_CODE  = 8'd1;
    localparam logic [7:0] BTN_RIGHT_CODE = 8'd3;

    typedef enum logic [2:0] {
        KIND_KEY_PRESS   = 3'd0,
        KIND_KEY_RELEASE = 3'd1,
        KIND_BTN_PRESS   = 3'd2,
        KIND_BTN_RELEASE = 3'd3,
        KIND_MOTION      = 3'd4
    } event_kind_t;

    typedef logic signed [MOTION_WIDTH-1:0] motion_t;

    // One parsed byte's worth of events, emitted in field order.
    typedef struct packed {
        logic       has_motion;
        motion_t    motion_x;
        motion_t    motion_y;
        logic       btn1_ev;
        logic       btn1_down;
        logic       btn3_ev;
        logic       btn3_down;
        logic       key_ev;
        logic       key_release;
        logic [7:0] key_code;
    } cmd_t;

    function automatic logic is_mouse_header(input logic [7:0] h);
        return (h >= MOUSE_HDR_LO) && (h <= MOUSE_HDR_HI);
    endfunction

    function automatic logic [2:0] header_rest(input logic [7:0] h);
        logic [2:0] r;
        if (is_mouse_header(h)) begin
            r = REST_MOUSE;
        end else begin
            case (h)
                HDR_STATUS:         r = REST_STATUS;
                HDR_ABS_POS:        r = REST_ABS;
                HDR_TIME:           r = REST_TIME;
                HDR_JOY0, HDR_JOY1: r = REST_JOY;
                default:            r = REST_NONE;
            endcase
        end
        return r;
    endfunction

    // Add a signed byte to an accumulator, clamping at the signed limits.
    function automatic motion_t sat_add(input motion_t acc, input logic [7:0] d);
        logic signed [MOTION_WIDTH:0] sum;
        motion_t                      res;
        sum = {acc[MOTION_WIDTH-1], acc} + {{(MOTION_WIDTH-7){d[7]}}, d};
        if (sum[MOTION_WIDTH] != sum[MOTION_WIDTH-1]) begin
            res = sum[MOTION_WIDTH] ? {1'b1, {(MOTION_WIDTH-1){1'b0}}}
                                    : {1'b0, {(MOTION_WIDTH-1){1'b1}}};
        end else begin
            res = sum[MOTION_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/kmpp_front.sv =====
// Parsing front end: accepts stream bytes, tracks packet state and motion,
// and pushes one event command per byte that causes results. Uses kmpp_pkg.
module kmpp_front
    import kmpp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic [7:0] key_offset,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    logic [2:0] bytes_left_reg, bytes_left_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] first_reg, first_next;
    motion_t    pend_dx_reg, pend_dx_next;
    motion_t    pend_dy_reg, pend_dy_next;
    logic [1:0] buttons_reg, buttons_next;

    logic       accept;
    logic       pend_nz;
    logic       mouse;
    motion_t    new_dx, new_dy;
    logic [1:0] diff;

    assign s_tready = cmd_ready;
    assign accept   = s_tvalid && s_tready;
    assign pend_nz  = (pend_dx_reg != '0) || (pend_dy_reg != '0);
    assign mouse    = is_mouse_header(header_reg);
    assign new_dx   = sat_add(pend_dx_reg, first_reg);
    assign new_dy   = sat_add(pend_dy_reg, s_tdata);
    assign diff     = header_reg[1:0] ^ buttons_reg;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        header_next     = header_reg;
        first_next      = first_reg;
        pend_dx_next    = pend_dx_reg;
        pend_dy_next    = pend_dy_reg;
        buttons_next    = buttons_reg;
        cmd             = '0;
        cmd_valid       = 1'b0;
        if (accept) begin
            if (s_tuser) begin
                if (pend_nz) begin
                    cmd.has_motion = 1'b1;
                    cmd.motion_x   = pend_dx_reg;
                    cmd.motion_y   = pend_dy_reg;
                    cmd_valid      = 1'b1;
                    pend_dx_next   = '0;
                    pend_dy_next   = '0;
                end
            end else if (bytes_left_reg != REST_NONE) begin
                if (mouse && bytes_left_reg == REST_DX) begin
                    first_next = s_tdata;
                end else if (mouse && bytes_left_reg == REST_DY) begin
                    buttons_next = header_reg[1:0];
                    if (diff != 2'b00) begin
                        cmd_valid      = 1'b1;
                        cmd.btn1_ev    = diff[1];
                        cmd.btn1_down  = header_reg[1];
                        cmd.btn3_ev    = diff[0];
                        cmd.btn3_down  = header_reg[0];
                        cmd.has_motion = (new_dx != '0) || (new_dy != '0);
                        cmd.motion_x   = new_dx;
                        cmd.motion_y   = new_dy;
                        pend_dx_next   = '0;
                        pend_dy_next   = '0;
                    end else begin
                        // no button change: motion stays pending
                        pend_dx_next = new_dx;
                        pend_dy_next = new_dy;
                    end
                end
                bytes_left_next = bytes_left_reg - 3'd1;
            end else if (s_tdata < FIRST_HEADER) begin
                cmd_valid       = 1'b1;
                cmd.has_motion  = pend_nz;
                cmd.motion_x    = pend_dx_reg;
                cmd.motion_y    = pend_dy_reg;
                cmd.key_ev      = 1'b1;
                cmd.key_release = s_tdata[7];
                cmd.key_code    = {1'b0, s_tdata[6:0]} + key_offset;
                pend_dx_next    = '0;
                pend_dy_next    = '0;
            end else begin
                header_next     = s_tdata;
                bytes_left_next = header_rest(s_tdata);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= REST_NONE;
            header_reg     <= '0;
            first_reg      <= '0;
            pend_dx_reg    <= '0;
            pend_dy_reg    <= '0;
            buttons_reg    <= '0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            header_reg     <= header_next;
            first_reg      <= first_next;
            pend_dx_reg    <= pend_dx_next;
            pend_dy_reg    <= pend_dy_next;
            buttons_reg    <= buttons_next;
        end
    end

endmodule

// ===== src/kmpp_cmd_fifo.sv =====
// Short command queue between the parsing front and the event back end.
// Register-based, CMD_FIFO_DEPTH entries of cmd_t. Uses kmpp_pkg.
module kmpp_cmd_fifo
    import kmpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                 mem [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != CMD_CNT_W'(CMD_FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/kmpp_back.sv =====
// Event back end: takes commands from the queue and expands each into one to
// three result transfers through a registered output stage. Uses kmpp_pkg.
module kmpp_back
    import kmpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    cmd_t        cur_reg, cur_next;
    logic        cur_valid_reg, cur_valid_next;
    logic        m_valid_reg, m_valid_next;
    event_kind_t kind_reg, kind_next;
    logic [7:0]  code_reg, code_next;
    logic [MOTION_OUT_W-1:0] mx_reg, mx_next;
    logic [MOTION_OUT_W-1:0] my_reg, my_next;
    logic        last_reg, last_next;

    logic        slot_free;
    logic        emit;
    cmd_t        rem;
    logic        rem_any;
    motion_t     cur_mx, cur_my;

    assign slot_free = !m_valid_reg || m_tready;
    assign emit      = cur_valid_reg && slot_free;
    assign cur_mx    = cur_reg.motion_x;
    assign cur_my    = cur_reg.motion_y;

    // Pick the next event of the current command: motion, button 1,
    // button 3, key; drop it from the remaining set.
    always_comb begin
        rem       = cur_reg;
        kind_next = kind_reg;
        code_next = code_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        if (cur_reg.has_motion) begin
            rem.has_motion = 1'b0;
            kind_next      = KIND_MOTION;
            code_next      = '0;
            mx_next        = MOTION_OUT_W'(cur_mx);
            my_next        = MOTION_OUT_W'(cur_my);
        end else if (cur_reg.btn1_ev) begin
            rem.btn1_ev = 1'b0;
            kind_next   = cur_reg.btn1_down ? KIND_BTN_PRESS : KIND_BTN_RELEASE;
            code_next   = BTN_LEFT_CODE;
            mx_next     = '0;
            my_next     = '0;
        end else if (cur_reg.btn3_ev) begin
            rem.btn3_ev = 1'b0;
            kind_next   = cur_reg.btn3_down ? KIND_BTN_PRESS : KIND_BTN_RELEASE;
            code_next   = BTN_RIGHT_CODE;
            mx_next     = '0;
            my_next     = '0;
        end else begin
            rem.key_ev = 1'b0;
            kind_next  = cur_reg.key_release ? KIND_KEY_RELEASE : KIND_KEY_PRESS;
            code_next  = cur_reg.key_code;
            mx_next    = '0;
            my_next    = '0;
        end
        rem_any   = rem.has_motion || rem.btn1_ev || rem.btn3_ev || rem.key_ev;
        last_next = !rem_any;
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        cmd_ready      = 1'b0;
        m_valid_next   = m_valid_reg;
        if (emit) begin
            cur_next       = rem;
            cur_valid_next = rem_any;
        end
        if (slot_free) begin
            m_valid_next = emit;
        end
        // refill the current command as soon as it runs dry
        if (!cur_valid_next && cmd_valid) begin
            cmd_ready      = 1'b1;
            cur_next       = cmd;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (emit) begin
            kind_reg <= kind_next;
            code_reg <= code_next;
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {my_reg, mx_reg, code_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/keyboard_mouse_packet_parser_unit.sv =====
// Keyboard/mouse packet parser, top level. The first result of a byte passes
// through the command queue and the current-command register into the output register.
// Throughput: one byte per cycle while the command queue has room, one result per
// cycle while m_tready is high; a byte with several results holds the output until all are sent.
// The output side, emitting one event per cycle, then sets the rate.
// Reset (aresetn, synchronous, low): no open packet, no motion, buttons up.
module keyboard_mouse_packet_parser_unit
    import kmpp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] func: 1 = flush pending motion
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] event_code, [23:8] motion_x, [39:24] motion_y
    output logic [2:0]  m_tuser,   // [2:0] event_kind
    output logic        m_tlast,   // last result caused by one input transfer
    // key_offset register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    // Key offset register: always writable, takes effect on the next byte.
    logic [7:0] key_offset_reg, key_offset_next;

    logic cmd_push_valid, cmd_push_ready;
    cmd_t cmd_push;
    logic cmd_pop_valid, cmd_pop_ready;
    cmd_t cmd_pop;

    assign cfg_ready       = 1'b1;
    assign key_offset_next = (cfg_valid && cfg_ready) ? cfg_data : key_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_offset_reg <= KEY_OFFSET_RESET;
        end else begin
            key_offset_reg <= key_offset_next;
        end
    end

    // Front: parse bytes, hold packet and motion state, build one command per
    // byte that has events.
    kmpp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .key_offset (key_offset_reg),
        .cmd_valid  (cmd_push_valid),
        .cmd_ready  (cmd_push_ready),
        .cmd        (cmd_push)
    );

    // Queue: lets the front keep taking bytes while the back end drains
    // multi-event commands or waits on m_tready.
    kmpp_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (cmd_push_valid),
        .push_ready (cmd_push_ready),
        .push_data  (cmd_push),
        .pop_valid  (cmd_pop_valid),
        .pop_ready  (cmd_pop_ready),
        .pop_data   (cmd_pop)
    );

    // Back end: expand each command into result transfers, in order.
    kmpp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_pop_valid),
        .cmd_ready (cmd_pop_ready),
        .cmd       (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking bench for keyboard_mouse_packet_parser_unit: random-paced byte stream in,
// parsed key, button and motion events out, checked against a cycle-free predictor.
// Depends on kmpp_pkg (event kinds, header codes, button codes, MOTION_WIDTH).
`timescale 1ns / 100ps

module tb;
    import kmpp_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    // Cycles to let the pipeline settle once nothing is expected; covers bytes with no result.
    localparam int          SETTLE      = 12;
    localparam logic        FUNC_STREAM = 1'b0;
    localparam logic        FUNC_FLUSH  = 1'b1;
    localparam logic [7:0]  SKIP_HDRS [6] = '{FIRST_HEADER, HDR_STATUS, HDR_ABS_POS,
                                             HDR_TIME, HDR_JOY0, HDR_JOY1};

    typedef struct {
        logic       func;
        logic [7:0] data;
    } stream_item_t;

    typedef struct {
        event_kind_t kind;
        logic [7:0]  code;
        logic [15:0] mx;
        logic [15:0] my;
        logic        last;
    } kbd_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tuser = 1'b0;   // [0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [7:0] event_code, [23:8] motion_x, [39:24] motion_y
    logic [2:0]  m_tuser;          // [2:0] event_kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    keyboard_mouse_packet_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stream_item_t byte_q[$];    // bytes waiting for the driver
    kbd_event_t   event_q[$];   // events predicted but not yet seen
    int           mismatches = 0;

    // Parser state as the predictor sees it.
    logic [7:0]   key_offset = KEY_OFFSET_RESET;
    logic [2:0]   open_left = '0;
    logic [7:0]   open_hdr = '0;
    logic [7:0]   held_dx = '0;
    longint       pend_x = 0;
    longint       pend_y = 0;
    logic [1:0]   btn_bits = '0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Total packet length, header included, for a header byte.
    function automatic int packet_len(input logic [7:0] h);
        if (h >= MOUSE_HDR_LO && h <= MOUSE_HDR_HI) return 3;
        case (h)
            HDR_STATUS:         return 6;
            HDR_ABS_POS:        return 7;
            HDR_TIME:           return 3;
            HDR_JOY0, HDR_JOY1: return 2;
            default:            return 1;
        endcase
    endfunction

    // Add a signed byte and clamp at the accumulator's signed limits.
    function automatic longint clamp_add(input longint acc, input logic [7:0] d);
        longint hi;
        longint s;
        hi = (longint'(1) << (MOTION_WIDTH - 1)) - 1;
        s = acc + longint'($signed(d));
        if (s > hi) s = hi;
        if (s < -hi - 1) s = -hi - 1;
        return s;
    endfunction

    function automatic void add_event(input event_kind_t kind, input logic [7:0] code,
                                      input longint mx, input longint my);
        kbd_event_t e;
        e.kind = kind;
        e.code = code;
        e.mx   = mx[15:0];
        e.my   = my[15:0];
        e.last = 1'b0;
        event_q.push_back(e);
    endfunction

    // Emit pending motion, if any, and clear it.
    function automatic void flush_motion();
        if (pend_x != 0 || pend_y != 0) begin
            add_event(KIND_MOTION, 8'd0, pend_x, pend_y);
            pend_x = 0;
            pend_y = 0;
        end
    endfunction

    function automatic void button_event(input logic [7:0] code, input logic down);
        flush_motion();
        add_event(down ? KIND_BTN_PRESS : KIND_BTN_RELEASE, code, 0, 0);
    endfunction

    // Advance the parser by one accepted byte and queue the events it causes.
    function automatic void parse_item(input logic func, input logic [7:0] b);
        int         first;
        logic       mouse;
        logic [1:0] btns;
        logic [1:0] diff;
        logic [7:0] code;
        first = event_q.size();
        mouse = open_hdr >= MOUSE_HDR_LO && open_hdr <= MOUSE_HDR_HI;
        if (func == FUNC_FLUSH) begin
            flush_motion();
        end else if (open_left != 0) begin
            if (mouse && open_left == 3'd2) begin
                held_dx = b;
            end else if (mouse && open_left == 3'd1) begin
                btns = open_hdr[1:0];
                diff = btns ^ btn_bits;
                pend_x = clamp_add(pend_x, held_dx);
                pend_y = clamp_add(pend_y, b);
                if (diff[1]) button_event(BTN_LEFT_CODE, btns[1]);
                if (diff[0]) button_event(BTN_RIGHT_CODE, btns[0]);
                btn_bits = btns;
            end
            open_left = open_left - 3'd1;
        end else if (b < FIRST_HEADER) begin
            code = {1'b0, b[6:0]} + key_offset;
            flush_motion();
            add_event(b[7] ? KIND_KEY_RELEASE : KIND_KEY_PRESS, code, 0, 0);
        end else begin
            open_hdr = b;
            open_left = 3'(packet_len(b) - 1);
        end
        if (event_q.size() > first) event_q[event_q.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Driver: one byte per transfer, random gap drawn per byte
    // ---------------------------------------------------------------
    int   send_gap = 0;
    logic send_burst = 1'b0;

    always @(posedge aclk) begin : drive_proc
        stream_item_t it;
        logic         nv;
        nv = s_tvalid;
        if (!aresetn) begin
            nv = 1'b0;
            send_gap = 0;
        end else begin
            // Predict on the transfer itself, with the values the block sampled.
            if (s_tvalid && s_tready) begin
                parse_item(s_tuser, s_tdata);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (byte_q.size() != 0) begin
                    it = byte_q.pop_front();
                    s_tdata <= it.data;
                    s_tuser <= it.func;
                    nv = 1'b1;
                    send_gap = send_burst ? 0 : $urandom_range(0, 8);
                    // Switch now and then between paced and back-to-back sending.
                    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
                end
            end
        end
        s_tvalid <= nv;
    end

    // ---------------------------------------------------------------
    // Monitor: random stall per result, compare with the oldest event
    // ---------------------------------------------------------------
    int   recv_stall = 0;
    logic recv_burst = 1'b0;

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : watch_proc
        kbd_event_t want;
        logic       nr;
        nr = m_tready;
        if (!aresetn) begin
            nr = 1'b0;
            recv_stall = 0;
        end else if (m_tvalid && m_tready) begin
            if (event_q.size() == 0) begin
                $error("unexpected result: kind %0d code 0x%0h", m_tuser, m_tdata[7:0]);
                mismatches++;
            end else begin
                want = event_q.pop_front();
                check_field("event_kind", 16'(want.kind), {13'b0, m_tuser});
                check_field("event_code", {8'b0, want.code}, {8'b0, m_tdata[7:0]});
                check_field("motion_x", want.mx, m_tdata[23:8]);
                check_field("motion_y", want.my, m_tdata[39:24]);
                check_field("last", {15'b0, want.last}, {15'b0, m_tlast});
            end
            recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
            nr = (recv_stall == 0);
        end else if (!m_tready) begin
            if (recv_stall != 0) recv_stall--;
            nr = (recv_stall == 0);
        end
        m_tready <= nr;
    end

    // Watchdog: a lost or stuck result ends the run here.
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout with %0d events still pending", event_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        stream_item_t it;
        it.func = FUNC_STREAM;
        it.data = b;
        byte_q.push_back(it);
    endfunction

    // Flush item; the data byte is ignored by the block, so randomize it.
    function automatic void push_flush();
        stream_item_t it;
        it.func = FUNC_FLUSH;
        it.data = 8'($urandom_range(0, 255));
        byte_q.push_back(it);
    endfunction

    function automatic void push_mouse(input logic [7:0] hdr, input logic [7:0] dx,
                                       input logic [7:0] dy);
        push_byte(hdr);
        push_byte(dx);
        push_byte(dy);
    endfunction

    // Motion byte, biased toward the signed extremes and zero.
    function automatic logic [7:0] rand_delta();
        logic [7:0] picks [4];
        picks = '{8'h7F, 8'h80, 8'h00, 8'hFF};
        if ($urandom_range(0, 3) == 0) return picks[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one random sequence; return how many bytes it added.
    function automatic int push_random_seq();
        int         sel;
        int         n;
        logic [7:0] hdr;
        sel = $urandom_range(0, 99);
        n = byte_q.size();
        if (sel < 35) begin
            // well-formed mouse packet, sometimes with a flush before dy
            push_byte(MOUSE_HDR_LO + 8'($urandom_range(0, 3)));
            push_byte(rand_delta());
            if ($urandom_range(0, 9) == 0) push_flush();
            push_byte(rand_delta());
        end else if (sel < 60) begin
            push_byte(8'($urandom_range(0, FIRST_HEADER - 1)));
        end else if (sel < 70) begin
            push_flush();
        end else if (sel < 85) begin
            // skipped packet with random payload, key-like bytes included
            hdr = SKIP_HDRS[$urandom_range(0, 5)];
            push_byte(hdr);
            for (int i = 1; i < packet_len(hdr); i++) push_byte(8'($urandom_range(0, 255)));
        end else if (sel < 95) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            // truncated mouse packet: whatever follows completes it
            push_byte(MOUSE_HDR_LO + 8'($urandom_range(0, 3)));
            push_byte(rand_delta());
        end
        return byte_q.size() - n;
    endfunction

    // Hold the sender until every queued byte is out and every event has come back.
    task automatic drain();
        @(negedge aclk);
        while (byte_q.size() != 0 || s_tvalid || event_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_key_offset(input logic [7:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        key_offset = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] offsets [4];
        int         count;
        offsets = '{8'd0, 8'd128, 8'd127, 8'($urandom_range(0, 128))};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset key offset.
        push_byte(8'h00);                       // press, lowest scan code
        push_byte(8'hF5);                       // release, highest key byte
        push_mouse(MOUSE_HDR_LO, 8'h7F, 8'h80); // motion, no button change: stays pending
        push_flush();                           // emit it
        push_flush();                           // zero motion: nothing
        push_mouse(MOUSE_HDR_HI, 8'h01, 8'hFF); // motion then both buttons pressed
        push_byte(MOUSE_HDR_LO + 8'd1);         // button 1 released, button 3 held
        push_flush();                           // flush inside the packet
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(FIRST_HEADER);                // one-byte header, dropped
        push_byte(HDR_JOY0);
        push_byte(8'h12);                       // payload below 0xF6, still skipped
        push_byte(HDR_JOY1);
        push_byte(8'h7F);
        push_byte(HDR_TIME);
        push_byte(8'h01);
        push_byte(8'h85);
        push_byte(8'h7F);                       // press, top scan code
        push_byte(8'hFF);                       // stray header byte opens a joystick packet
        push_byte(8'h80);
        drain();

        // Random part in chunks; rewrite the key offset between chunks.
        for (int c = 0; c < 4; c++) begin
            write_key_offset(offsets[c]);
            count = 0;
            while (count < 33) count += push_random_seq();
            drain();
        end

        // Accumulate motion over several packets, negative then positive.
        push_mouse(MOUSE_HDR_LO, 8'h00, 8'h00);
        for (int i = 0; i < 3; i++) push_mouse(MOUSE_HDR_LO, 8'h80, 8'h80);
        push_flush();
        for (int i = 0; i < 3; i++) push_mouse(MOUSE_HDR_LO, 8'h7F, 8'h7F);
        push_byte(8'h80);                       // key event flushes the motion first
        drain();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
